/* rtl/mncp_pkg.sv */
// ----------------------------------------------------------------------------
// mncp_pkg: shared definitions of the MIDI note and control change parser
// Message type codes, event kind codes and the field widths of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package mncp_pkg;

  // Field widths of the byte channel and the event channel.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 7;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned TypeW  = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned LevelW = 12;

  // Message types taken from bits 6:4 of a status byte.
  localparam logic [TypeW-1:0] TYPE_NOTE_OFF = 3'd0;
  localparam logic [TypeW-1:0] TYPE_NOTE_ON  = 3'd1;
  localparam logic [TypeW-1:0] TYPE_CTRL_CHG = 3'd3;

  // Event kinds reported on the event channel.
  typedef enum logic [KindW-1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_CTRL_CHG = 2'd2
  } event_kind_e;

endpackage

`default_nettype wire

/* rtl/mncp_if.sv */
// ----------------------------------------------------------------------------
// mncp_if: channel interfaces of the MIDI parser
// A byte channel that carries received MIDI bytes and an event channel that
// carries decoded note and control change events, both valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mncp_byte_if
  import mncp_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] midi_byte;

  modport source (output valid, output midi_byte, input ready);
  modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mncp_event_if
  import mncp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  event_kind;
  logic [ChanW-1:0]  channel;
  logic [DataW-1:0]  first_data;
  logic [DataW-1:0]  second_data;
  logic [LevelW-1:0] cv_level;

  modport source (output valid, output event_kind, output channel, output first_data,
                  output second_data, output cv_level, input ready);
  modport sink   (input valid, input event_kind, input channel, input first_data,
                  input second_data, input cv_level, output ready);
endinterface

`default_nettype wire

/* rtl/mncp_cv_scale.sv */
// ----------------------------------------------------------------------------
// mncp_cv_scale: controller value to 12-bit level
// Computes value * 4095 / 127, truncated, without a divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mncp_cv_scale
  import mncp_pkg::*;
(
  input  wire logic [DataW-1:0]  value_i,
  output      logic [LevelW-1:0] level_o
);

  // 4095 = 32 * 127 + 31, so the level is 32 * v + floor(31 * v / 127).
  logic [11:0] rem_num;
  logic [18:0] recip_prod;
  logic [4:0]  quot_est;
  logic [12:0] remainder;
  logic [4:0]  quot;

  // 31 * v is at most 3937.
  assign rem_num = {value_i, 5'b0} - {5'b0, value_i};

  // 129 / 16384 sits just below 1 / 127, so the estimate is low by at most one.
  assign recip_prod = {rem_num, 7'b0} + {7'b0, rem_num};
  assign quot_est   = recip_prod[18:14];

  // One compare fixes the estimate.
  assign remainder = {1'b0, rem_num} - {1'b0, quot_est, 7'b0} + {8'b0, quot_est};
  assign quot      = (remainder >= 13'd127) ? quot_est + 5'd1 : quot_est;

  assign level_o = {value_i, 5'b0} + {7'b0, quot};

endmodule

`default_nettype wire

/* rtl/midi_note_cc_parser.sv */
// ----------------------------------------------------------------------------
// midi_note_cc_parser: MIDI note and control change parser
// Decodes a stream of MIDI bytes with running status into note and control
// change events.
// ----------------------------------------------------------------------------
// The parser takes one MIDI byte per beat and can accept a byte in every
// cycle unless a byte that completes an event is held back by a full
// output. A byte sits in an input register, where it is decoded against the
// running status and the held first data byte in a single pass; an event
// that it completes is registered for the event channel. The output register lets
// the next byte in while an event waits to be taken. Status bytes set the
// message type and channel and restart collection at the first data byte.
// Only note off, note on and control change data bytes produce events;
// control changes also carry the value scaled to 0..4095 in cv_level.
`default_nettype none

module midi_note_cc_parser
  import mncp_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  mncp_byte_if.sink    midi_i,
  mncp_event_if.source event_o
);

  // Input register.
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] byte_q;

  // Running status.
  logic [TypeW-1:0] msg_type_q;
  logic [ChanW-1:0] chan_q;
  logic             awaiting_q;
  logic [DataW-1:0] held_q;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [KindW-1:0]  kind_q;
  logic [ChanW-1:0]  out_chan_q;
  logic [DataW-1:0]  first_q;
  logic [DataW-1:0]  second_q;
  logic [LevelW-1:0] level_q;

  logic              in_fire;
  logic              is_status;
  logic              type_ok;
  logic              emit;
  logic              out_free;
  logic              advance;
  event_kind_e       kind;
  logic [LevelW-1:0] scaled;
  logic [LevelW-1:0] level;

  // Decode of the byte in the input register.
  assign is_status = byte_q[ByteW-1];
  assign type_ok   = (msg_type_q == TYPE_NOTE_OFF) || (msg_type_q == TYPE_NOTE_ON) ||
                     (msg_type_q == TYPE_CTRL_CHG);
  assign emit      = !is_status && type_ok && awaiting_q;

  always_comb begin
    case (msg_type_q)
      TYPE_NOTE_ON:  kind = KIND_NOTE_ON;
      TYPE_CTRL_CHG: kind = KIND_CTRL_CHG;
      default:       kind = KIND_NOTE_OFF;
    endcase
  end

  mncp_cv_scale u_cv_scale (
    .value_i (byte_q[DataW-1:0]),
    .level_o (scaled)
  );

  assign level = (kind == KIND_CTRL_CHG) ? scaled : '0;

  // Handshakes: a byte moves on unless its event is blocked by a full output.
  assign out_free     = !out_valid_q || event_o.ready;
  assign advance      = in_valid_q && (!emit || out_free);
  assign midi_i.ready = !in_valid_q || advance;
  assign in_fire      = midi_i.valid && midi_i.ready;

  assign in_valid_d  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = (advance && emit) ? 1'b1 : (event_o.ready ? 1'b0 : out_valid_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      msg_type_q  <= '0;
      chan_q      <= '0;
      awaiting_q  <= 1'b0;
      held_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        if (is_status) begin
          msg_type_q <= byte_q[ByteW-2 -: TypeW];
          chan_q     <= byte_q[ChanW-1:0];
          awaiting_q <= 1'b0;
        end else if (type_ok) begin
          if (!awaiting_q) begin
            held_q <= byte_q[DataW-1:0];
          end
          awaiting_q <= !awaiting_q;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= midi_i.midi_byte;
    end
    if (advance && emit) begin
      kind_q     <= kind;
      out_chan_q <= chan_q;
      first_q    <= held_q;
      second_q   <= byte_q[DataW-1:0];
      level_q    <= level;
    end
  end

  assign event_o.valid       = out_valid_q;
  assign event_o.event_kind  = kind_q;
  assign event_o.channel     = out_chan_q;
  assign event_o.first_data  = first_q;
  assign event_o.second_data = second_q;
  assign event_o.cv_level    = level_q;

  // A status byte always restarts collection at the first data byte.
  a_status_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_status) |=> !awaiting_q)
    else $error("status byte did not restart data collection");

  // An event only completes a pair, which clears the second-byte flag.
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (!awaiting_q && out_valid_q))
    else $error("completed pair did not clear the flag or raise an event");

  // Note events carry no level.
  a_note_no_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (kind_q != KIND_CTRL_CHG)) |-> (level_q == '0))
    else $error("note event with a nonzero level");

  // A byte held back by a full output stays in the input register.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(byte_q)))
    else $error("stalled byte lost from the input register");

endmodule

`default_nettype wire
